### rtl/joystick_axis_conditioner_macros.svh
// ---------------------------------------------------------------------------
// Joystick axis conditioner assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ---------------------------------------------------------------------------
`ifndef JOYSTICK_AXIS_CONDITIONER_MACROS_SVH
`define JOYSTICK_AXIS_CONDITIONER_MACROS_SVH

// hold in the same cycle
`define JAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// hold in the next cycle
`define JAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/jac_pkg.sv
// ---------------------------------------------------------------------------
// Joystick axis conditioner package
// Widths, register indexes, control word layout and the sequencer program.
// ---------------------------------------------------------------------------
package jac_pkg;

    localparam int WINDOW     = 5;
    localparam int SAMPLE_W   = 12;
    localparam int SCALE_W    = 10;
    localparam int DEAD_W     = 10;
    localparam int AXIS_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
    localparam int DIV_W = SAMPLE_W + SCALE_W;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int PC_W  = 3;

    // window mean as (sum * MEAN_MULT) >> MEAN_SHIFT, exact over the sum range
    localparam int MEAN_SHIFT = SUM_W + 4;
    localparam int MULT_W     = MEAN_SHIFT + 1;
    localparam logic [MULT_W-1:0] MEAN_MULT = MULT_W'(((1 << MEAN_SHIFT) + WINDOW - 1) / WINDOW);

    localparam logic [CFG_ADDR_W-1:0] REG_CENTER = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE  = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD   = CFG_ADDR_W'(2);

    localparam logic [SAMPLE_W-1:0] CENTER_RESET = SAMPLE_W'(2048);
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = SCALE_W'(255);
    localparam logic [DEAD_W-1:0]   DEAD_RESET   = DEAD_W'(30);

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_MEAN,
        OP_DELTA,
        OP_DIV_SCALE,
        OP_DIV_STEP,
        OP_DEAD,
        OP_SAT,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        C_NEVER,
        C_NO_INPUT,
        C_DIV_BUSY,
        C_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    localparam logic [PC_W-1:0] PC_WAIT     = PC_W'(0);
    localparam logic [PC_W-1:0] PC_DIV_SCL  = PC_W'(4);
    localparam logic [PC_W-1:0] PC_EMIT     = PC_W'(7);

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{op: OP_LOAD, cond: C_NO_INPUT, target: PC_WAIT};
        case (pc)
            PC_W'(0): w = '{op: OP_LOAD,      cond: C_NO_INPUT, target: PC_WAIT};
            PC_W'(1): w = '{op: OP_MEAN,      cond: C_NEVER,    target: PC_WAIT};
            PC_W'(2): w = '{op: OP_DELTA,     cond: C_NEVER,    target: PC_WAIT};
            PC_W'(3): w = '{op: OP_DIV_SCALE, cond: C_NEVER,    target: PC_WAIT};
            PC_W'(4): w = '{op: OP_DIV_STEP,  cond: C_DIV_BUSY, target: PC_DIV_SCL};
            PC_W'(5): w = '{op: OP_DEAD,      cond: C_NEVER,    target: PC_WAIT};
            PC_W'(6): w = '{op: OP_SAT,       cond: C_NEVER,    target: PC_WAIT};
            PC_W'(7): w = '{op: OP_EMIT,      cond: C_OUT_FULL, target: PC_EMIT};
            default:  w = '{op: OP_LOAD,      cond: C_NO_INPUT, target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

### rtl/joystick_axis_conditioner.sv
// ---------------------------------------------------------------------------
// Joystick axis conditioner
// Moving average, centring, scaling, dead zone and saturation of one axis.
// ---------------------------------------------------------------------------
// Each input word carries one 12-bit ADC sample and yields one 16-bit signed
// output word. A sample is taken only while the sequencer waits at its first
// step; a word then passes to the output register through one load step,
// the window mean by reciprocal multiplication, centring, divider set-up,
// the bit-serial divider (scaled deflection over the centre), dead zone,
// saturation and the emit step. The emit step holds while the output
// register still holds a word not yet taken. The sequencer returns to its
// first step for the next sample in the cycle after the emit step, so no new
// sample is taken before the last word reaches the output register.
// Configuration: cfg_addr 0 centre, 1 scale, 2 dead zone; other indexes are
// ignored. Write only while no sample is in flight.
`include "joystick_axis_conditioner_macros.svh"

module joystick_axis_conditioner
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [jac_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [jac_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [jac_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [11:0] sample
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [jac_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // [15:0] axis_value
);
    import jac_pkg::*;

    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [SAMPLE_W-1:0] center_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [DEAD_W-1:0]   dead_reg;
    logic [SAMPLE_W-1:0] ring_reg [WINDOW];
    logic [SAMPLE_W-1:0] ring_next [WINDOW];
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                out_valid_reg, out_valid_next;
    logic [AXIS_W-1:0]   out_data_reg, out_data_next;

    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [SAMPLE_W-1:0] rem_reg, rem_next;
    logic [SAMPLE_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [AXIS_W-1:0]   res_reg, res_next;

    uword_t              uw;
    logic                jump;
    logic                out_full;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W:0]   trial;
    logic [SAMPLE_W+1:0] diff;
    logic                ge;
    logic [SAMPLE_W:0]   delta;
    logic [SAMPLE_W:0]   delta_neg;
    logic [DIV_W-1:0]    qd;
    logic [SUM_W+MULT_W-1:0] mean_prod;
    logic [SUM_W-1:0]    ring_total;

    assign uw       = ucode(pc_reg);
    assign out_full = out_valid_reg && !m_axis_tready;
    assign sample   = s_axis_tdata[SAMPLE_W-1:0];

    assign s_axis_tready = (uw.op == OP_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign trial     = {rem_reg, quo_reg[DIV_W-1]};
    assign diff      = {1'b0, trial} - {2'b00, dvs_reg};
    assign ge        = !diff[SAMPLE_W+1];
    assign delta     = {1'b0, quo_reg[SAMPLE_W-1:0]} - {1'b0, center_reg};
    assign delta_neg = (SAMPLE_W+1)'(0) - delta;
    assign qd        = (quo_reg < DIV_W'(dead_reg)) ? '0 : quo_reg;
    assign mean_prod = (SUM_W+MULT_W)'(sum_reg) * (SUM_W+MULT_W)'(MEAN_MULT);

    always_comb
    begin
        case (uw.cond)
            C_NEVER:    jump = 1'b0;
            C_NO_INPUT: jump = !s_axis_tvalid;
            C_DIV_BUSY: jump = (cnt_reg != CNT_W'(1));
            C_OUT_FULL: jump = out_full;
            default:    jump = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next        = jump ? uw.target : pc_reg + PC_W'(1);
        ring_next      = ring_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        case (uw.op)
            OP_LOAD:
            begin
                if (s_axis_tvalid)
                begin
                    sum_next           = sum_reg - SUM_W'(ring_reg[idx_reg]) + SUM_W'(sample);
                    ring_next[idx_reg] = sample;
                    idx_next           = (idx_reg == IDX_W'(WINDOW - 1)) ? '0
                                                                          : idx_reg + IDX_W'(1);
                end
            end
            OP_MEAN:
            begin
                quo_next = DIV_W'(mean_prod[SUM_W+MULT_W-1:MEAN_SHIFT]);
            end
            OP_DIV_STEP:
            begin
                rem_next = ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], ge};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            OP_DELTA:
            begin
                neg_next = delta[SAMPLE_W];
                mag_next = delta[SAMPLE_W] ? delta_neg[SAMPLE_W-1:0] : delta[SAMPLE_W-1:0];
            end
            OP_DIV_SCALE:
            begin
                quo_next = DIV_W'(mag_reg) * DIV_W'(scale_reg);
                rem_next = '0;
                dvs_next = (center_reg == '0) ? SAMPLE_W'(1) : center_reg;
                cnt_next = CNT_W'(DIV_W);
            end
            OP_DEAD:
            begin
                quo_next = qd;
            end
            OP_SAT:
            begin
                if (neg_reg)
                begin
                    res_next = (quo_reg > DIV_W'(32767)) ? AXIS_W'(16'h7fff)
                                                          : quo_reg[AXIS_W-1:0];
                end
                else
                begin
                    res_next = (quo_reg > DIV_W'(32768)) ? AXIS_W'(16'h8000)
                                                          : AXIS_W'(0) - quo_reg[AXIS_W-1:0];
                end
            end
            OP_EMIT:
            begin
                if (!out_full)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default:
            begin
                pc_next = pc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_WAIT;
            center_reg    <= CENTER_RESET;
            scale_reg     <= SCALE_RESET;
            dead_reg      <= DEAD_RESET;
            ring_reg      <= '{default: '0};
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            ring_reg      <= ring_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_CENTER: center_reg <= cfg_wdata[SAMPLE_W-1:0];
                    REG_SCALE:  scale_reg  <= cfg_wdata[SCALE_W-1:0];
                    REG_DEAD:   dead_reg   <= cfg_wdata[DEAD_W-1:0];
                    default:    center_reg <= center_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        cnt_reg      <= cnt_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        ring_total = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            ring_total = ring_total + SUM_W'(ring_reg[i]);
        end
    end

    `JAC_ASSERT_NOW(a_sum_tracks_ring, 1'b1, sum_reg == ring_total,
        "running sum differs from ring contents")
    `JAC_ASSERT_NOW(a_index_in_range, 1'b1, idx_reg <= IDX_W'(WINDOW - 1),
        "ring index beyond window")
    `JAC_ASSERT_NOW(a_div_remainder, uw.op == OP_DIV_STEP, rem_reg < dvs_reg,
        "divider remainder not below divisor")
    `JAC_ASSERT_NEXT(a_emit_loads, uw.op == OP_EMIT && !out_full, m_axis_tvalid,
        "emit step did not load the output register")

endmodule
